/* hw/rtl/lsq_pkg.sv */
package lsq_pkg;

  localparam int WORD_W        = 32;
  localparam int OP_W          = 3;
  localparam int IDX_W         = 6;
  localparam int DEFAULT_DEPTH = 64;
  localparam int MAX_DEPTH     = 1024;
  localparam int POS_W         = $clog2(MAX_DEPTH);

  // op, value, index packed from bit 0 up, padded to bytes
  localparam int IN_W = ((OP_W + WORD_W + IDX_W + 7) / 8) * 8;

  // result fields except entry_count: top, min, max, query value, empty, hit, error
  localparam int RES_FIXED_W = 4 * WORD_W + 3;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_DUP,
    OP_REVERSE,
    OP_PEEK,
    OP_CONTAINS
  } op_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP,
    CMD_CLEAR,
    CMD_ROTATE,
    CMD_SEED_SCAN,
    CMD_SEED_ALL,
    CMD_STEP
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_FIX,
    ST_SCAN
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_t        cmd;
    logic [POS_W-1:0] pos;
    word_t            din;
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic  v;
    word_t e;
    word_t mn;
    word_t mx;
    word_t sc;
  } cell_link_t;

endpackage

/* hw/rtl/lsq_cell.sv */
module lsq_cell #(
  parameter int POS = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lsq_pkg::cell_ctl_t  ctl,
  input  lsq_pkg::cell_link_t up,
  input  lsq_pkg::cell_link_t dn,
  output lsq_pkg::cell_link_t cur
);
  import lsq_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

  logic  v, v_next;
  word_t e, e_next;
  word_t mn, mn_next;
  word_t mx, mx_next;
  word_t sc, sc_next;

  always_comb begin
    v_next  = v;
    e_next  = e;
    mn_next = mn;
    mx_next = mx;
    sc_next = sc;
    case (ctl.cmd)
      CMD_PUSH: begin
        v_next  = up.v;
        e_next  = up.e;
        mn_next = up.mn;
        mx_next = up.mx;
      end
      CMD_POP: begin
        v_next  = dn.v;
        e_next  = dn.e;
        mn_next = dn.mn;
        mx_next = dn.mx;
      end
      CMD_CLEAR: begin
        v_next = 1'b0;
      end
      CMD_ROTATE: begin
        // top word drops into slot pos, everything above it moves up one
        if (MY_POS < ctl.pos) begin
          e_next = dn.e;
        end else if (MY_POS == ctl.pos) begin
          e_next = ctl.din;
        end
      end
      CMD_SEED_SCAN: begin
        sc_next = e;
      end
      CMD_SEED_ALL: begin
        sc_next = e;
        mn_next = e;
        mx_next = e;
      end
      CMD_STEP: begin
        // scan word moves toward the top, min/max fold in from below
        sc_next = dn.sc;
        if (dn.v) begin
          if (dn.mn < mn) mn_next = dn.mn;
          if (dn.mx > mx) mx_next = dn.mx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    e  <= e_next;
    mn <= mn_next;
    mx <= mx_next;
    sc <= sc_next;
  end

  assign cur = '{v: v, e: e, mn: mn, mx: mx, sc: sc};

endmodule

/* hw/rtl/lsq_ctrl.sv */
module lsq_ctrl #(
  parameter  int STACK_DEPTH = lsq_pkg::DEFAULT_DEPTH,
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1),
  localparam int OUT_W       = ((lsq_pkg::RES_FIXED_W + CNT_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [lsq_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata,
  input  lsq_pkg::cell_link_t      c0,
  output lsq_pkg::cell_ctl_t       ctl,
  output lsq_pkg::cell_link_t      feed
);
  import lsq_pkg::*;

  localparam int CMP_W = CNT_W + IDX_W;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   ptr, ptr_next;
  logic               rep_valid, rep_valid_next;
  word_t              qval, qval_next;
  logic               qhit, qhit_next;
  logic               err, err_next;
  op_t                op_q;
  word_t              val_q;
  logic [IDX_W-1:0]   idx_q;

  op_t                in_op;
  word_t              in_val;
  logic [IDX_W-1:0]   in_idx;
  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;
  logic               done;
  word_t              feed_e;
  word_t              top_o, mn_o, mx_o;
  logic [OUT_W-1:0]   rep;

  assign in_op  = op_t'(s_tdata[OP_W-1:0]);
  assign in_val = word_t'(s_tdata[OP_W +: WORD_W]);
  assign in_idx = s_tdata[OP_W + WORD_W +: IDX_W];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && (!rep_valid || out_free);
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign empty    = (count == '0);

  // new top word for push and duplicate, with its min/max over the rest
  assign feed = '{
    v:  1'b1,
    e:  feed_e,
    mn: (c0.v && (c0.mn < feed_e)) ? c0.mn : feed_e,
    mx: (c0.v && (c0.mx > feed_e)) ? c0.mx : feed_e,
    sc: '0
  };

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    qval_next  = qval;
    qhit_next  = qhit;
    err_next   = err;
    done       = 1'b0;
    feed_e     = in_val;
    ctl        = '{cmd: CMD_HOLD, pos: '0, din: c0.e};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          qval_next = '0;
          qhit_next = 1'b0;
          err_next  = 1'b0;
          case (in_op)
            OP_PUSH: begin
              done = 1'b1;
              if (full) begin
                err_next = 1'b1;
              end else begin
                ctl.cmd    = CMD_PUSH;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP: begin
              done = 1'b1;
              if (empty) begin
                err_next = 1'b1;
              end else begin
                ctl.cmd    = CMD_POP;
                count_next = count - CNT_W'(1);
              end
            end
            OP_CLEAR: begin
              done       = 1'b1;
              ctl.cmd    = CMD_CLEAR;
              count_next = '0;
            end
            OP_DUP: begin
              done   = 1'b1;
              feed_e = c0.e;
              if (empty || full) begin
                err_next = 1'b1;
              end else begin
                ctl.cmd    = CMD_PUSH;
                count_next = count + CNT_W'(1);
              end
            end
            OP_REVERSE: begin
              if (count > CNT_W'(1)) begin
                ctl.cmd    = CMD_ROTATE;
                ctl.pos    = POS_W'(count - CNT_W'(1));
                ptr_next   = count - CNT_W'(2);
                state_next = ST_ROT;
              end else begin
                done = 1'b1;
              end
            end
            OP_PEEK: begin
              if (CMP_W'(in_idx) < CMP_W'(count)) begin
                ctl.cmd    = CMD_SEED_SCAN;
                ptr_next   = '0;
                state_next = ST_SCAN;
              end else begin
                qval_next = '1;
                done      = 1'b1;
              end
            end
            OP_CONTAINS: begin
              if (empty) begin
                done = 1'b1;
              end else begin
                ctl.cmd    = CMD_SEED_SCAN;
                ptr_next   = '0;
                state_next = ST_SCAN;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_ROT: begin
        // slot 0 needs no move, so the last step reseeds min/max instead
        if (ptr != '0) begin
          ctl.cmd  = CMD_ROTATE;
          ctl.pos  = POS_W'(ptr);
          ptr_next = ptr - CNT_W'(1);
        end else begin
          ctl.cmd    = CMD_SEED_ALL;
          ptr_next   = CNT_W'(1);
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        ctl.cmd = CMD_STEP;
        if (ptr == count - CNT_W'(1)) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + CNT_W'(1);
        end
      end
      ST_SCAN: begin
        // c0.sc holds the word ptr places below the top
        if (op_q == OP_PEEK) begin
          if (CMP_W'(ptr) == CMP_W'(idx_q)) begin
            qval_next  = c0.sc;
            qhit_next  = 1'b1;
            done       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            ctl.cmd  = CMD_STEP;
            ptr_next = ptr + CNT_W'(1);
          end
        end else begin
          if (c0.sc == val_q) begin
            qhit_next  = 1'b1;
            done       = 1'b1;
            state_next = ST_IDLE;
          end else if (ptr == count - CNT_W'(1)) begin
            done       = 1'b1;
            state_next = ST_IDLE;
          end else begin
            ctl.cmd  = CMD_STEP;
            ptr_next = ptr + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    rep_valid_next = done || (rep_valid && !out_free);
  end

  assign top_o = c0.v ? c0.e  : '0;
  assign mn_o  = c0.v ? c0.mn : '0;
  assign mx_o  = c0.v ? c0.mx : '0;
  assign rep   = OUT_W'({err, qhit, qval, mx_o, mn_o, empty, count, top_o});

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ptr       <= '0;
      rep_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      ptr       <= ptr_next;
      rep_valid <= rep_valid_next;
      if (rep_valid && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    qval <= qval_next;
    qhit <= qhit_next;
    err  <= err_next;
    if (accept) begin
      op_q  <= in_op;
      val_q <= in_val;
      idx_q <= in_idx;
    end
    if (rep_valid && out_free) begin
      m_tdata <= rep;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_top_valid: assert property (@(posedge clk) disable iff (rst)
    c0.v == (count != '0))
    else $error("top cell valid flag disagrees with count");

  a_rep_idle: assert property (@(posedge clk) disable iff (rst)
    rep_valid |-> state == ST_IDLE)
    else $error("result pending while an op is still running");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    accept && (in_op == OP_PUSH) && !full |=> c0.e == $past(in_val))
    else $error("pushed word not on top");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> ptr < count)
    else $error("scan ran past the held entries");

endmodule

/* hw/rtl/lifo_stack_with_queries_top.sv */
// channel  dir  tdata fields, bit 0 up                                    handshake
// s        in   op[2:0] value[34:3] index[40:35], zero pad to 48          s_tvalid/s_tready
// m        out  top_value entry_count is_empty min_value max_value        m_tvalid/m_tready
//               query_value query_hit error, zero pad to whole bytes
//
// push, pop, clear, duplicate, out-of-range peek: done on acceptance; result registered
// peek at index i: the scan word walks up the cell chain one slot a cycle
// contains: same chain walk, stops at the first match
// reverse: count-1 rotates, a reseed, then count-1 min/max fold steps
// rst clears the count, the cell valid bits and both result valid flags; no clearing pass
// a new word is taken while a result waits in the output register; the one after waits
module lifo_stack_with_queries_top #(
  parameter  int STACK_DEPTH = lsq_pkg::DEFAULT_DEPTH,
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1),
  localparam int OUT_W       = ((lsq_pkg::RES_FIXED_W + CNT_W + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // op, value, index
  input  logic [lsq_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // top_value, entry_count, is_empty, min_value, max_value, query_value, query_hit, error
  output logic [OUT_W-1:0]         m_tdata
);
  import lsq_pkg::*;

  cell_ctl_t  ctl;
  cell_link_t feed;
  cell_link_t lnk [STACK_DEPTH];

  lsq_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .c0      (lnk[0]),
    .ctl     (ctl),
    .feed    (feed)
  );

  // cell 0 holds the top; deeper entries sit at higher positions
  for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
    cell_link_t up_l;
    cell_link_t dn_l;

    if (gi == 0) begin : g_first
      assign up_l = feed;
    end else begin : g_up
      assign up_l = lnk[gi-1];
    end

    if (gi == STACK_DEPTH - 1) begin : g_last
      assign dn_l = '0;
    end else begin : g_dn
      assign dn_l = lnk[gi+1];
    end

    lsq_cell #(
      .POS(gi)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .up (up_l),
      .dn (dn_l),
      .cur(lnk[gi])
    );
  end

endmodule

/* test/lsq_checker.sv */
`timescale 1ns / 100ps

module lsq_checker #(
  parameter int DEPTH = lsq_pkg::DEFAULT_DEPTH,
  parameter int OUT_W = 144
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [lsq_pkg::IN_W-1:0] s_tdata,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_W-1:0]         m_tdata,
  output int                       mismatches,
  output int                       pending
);
  import lsq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // result word layout, bit 0 up
  localparam int CNT_LSB   = WORD_W;
  localparam int EMPTY_BIT = CNT_LSB + CNT_W;
  localparam int MIN_LSB   = EMPTY_BIT + 1;
  localparam int MAX_LSB   = MIN_LSB + WORD_W;
  localparam int QV_LSB    = MAX_LSB + WORD_W;
  localparam int HIT_BIT   = QV_LSB + WORD_W;
  localparam int ERR_BIT   = HIT_BIT + 1;

  typedef struct {
    word_t            top;
    logic [CNT_W-1:0] cnt;
    logic             empty;
    word_t            mn;
    word_t            mx;
    word_t            qv;
    logic             hit;
    logic             err;
  } stack_status_t;

  word_t         slots [DEPTH];
  int            held = 0;
  int            fail_cnt = 0;
  stack_status_t status_q [$];

  function automatic stack_status_t apply_op(logic [OP_W-1:0] op, word_t val,
                                             logic [IDX_W-1:0] idx);
    stack_status_t s;
    word_t         t;
    int            lo;
    int            hi;
    s.qv  = '0;
    s.hit = 1'b0;
    s.err = 1'b0;
    case (op)
      OP_PUSH: begin
        if (held >= DEPTH) begin
          s.err = 1'b1;
        end else begin
          slots[held] = val;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) s.err = 1'b1;
        else held--;
      end
      OP_CLEAR: held = 0;
      OP_DUP: begin
        if (held == 0 || held >= DEPTH) begin
          s.err = 1'b1;
        end else begin
          slots[held] = slots[held-1];
          held++;
        end
      end
      OP_REVERSE: begin
        lo = 0;
        hi = held - 1;
        while (lo < hi) begin
          t         = slots[lo];
          slots[lo] = slots[hi];
          slots[hi] = t;
          lo++;
          hi--;
        end
      end
      OP_PEEK: begin
        if (int'(idx) < held) begin
          s.qv  = slots[held-1-int'(idx)];
          s.hit = 1'b1;
        end else begin
          s.qv = -1;
        end
      end
      OP_CONTAINS: begin
        for (int i = 0; i < held; i++)
          if (slots[i] == val) s.hit = 1'b1;
      end
      default: ;
    endcase
    s.top = '0;
    s.mn  = '0;
    s.mx  = '0;
    if (held > 0) begin
      s.top = slots[held-1];
      s.mn  = slots[0];
      s.mx  = slots[0];
      for (int i = 1; i < held; i++) begin
        if (slots[i] < s.mn) s.mn = slots[i];
        if (slots[i] > s.mx) s.mx = slots[i];
      end
    end
    s.cnt   = held[CNT_W-1:0];
    s.empty = (held == 0);
    return s;
  endfunction

  always @(posedge clk) begin
    stack_status_t got;
    stack_status_t want;
    if (rst) begin
      held = 0;
      status_q.delete();
    end else begin
      // results first: a word accepted now cannot produce its result at this edge
      if (m_tvalid && m_tready) begin
        got.top   = m_tdata[0 +: WORD_W];
        got.cnt   = m_tdata[CNT_LSB +: CNT_W];
        got.empty = m_tdata[EMPTY_BIT];
        got.mn    = m_tdata[MIN_LSB +: WORD_W];
        got.mx    = m_tdata[MAX_LSB +: WORD_W];
        got.qv    = m_tdata[QV_LSB +: WORD_W];
        got.hit   = m_tdata[HIT_BIT];
        got.err   = m_tdata[ERR_BIT];
        if (status_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result word with no op outstanding, top=%0d cnt=%0d",
                     $time, got.top, got.cnt);
        end else begin
          want = status_q.pop_front();
          if (got.top !== want.top || got.cnt !== want.cnt || got.empty !== want.empty ||
              got.mn !== want.mn || got.mx !== want.mx || got.qv !== want.qv ||
              got.hit !== want.hit || got.err !== want.err) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: exp top=%0d cnt=%0d empty=%0b min=%0d max=%0d q=%0d hit=%0b err=%0b",
                       $time, want.top, want.cnt, want.empty, want.mn, want.mx, want.qv,
                       want.hit, want.err);
              $display("%0t: got top=%0d cnt=%0d empty=%0b min=%0d max=%0d q=%0d hit=%0b err=%0b",
                       $time, got.top, got.cnt, got.empty, got.mn, got.mx, got.qv,
                       got.hit, got.err);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        status_q.push_back(apply_op(s_tdata[0 +: OP_W], s_tdata[OP_W +: WORD_W],
                                    s_tdata[OP_W+WORD_W +: IDX_W]));
    end
    pending    <= status_q.size();
    mismatches <= fail_cnt;
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import lsq_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int OUT_W        = ((RES_FIXED_W + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 800;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 200;
  localparam int DRAIN_CYCLES = 150;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // traffic mixes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_ANY   = 2;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             hold_off = 1'b0;

  int mismatches;
  int pending;
  int words_sent = 0;
  int send_burst = 0;
  int recv_burst = 0;

  lifo_stack_with_queries_top #(.STACK_DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lsq_checker #(.DEPTH(DEPTH), .OUT_W(OUT_W)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_op(logic [OP_W-1:0] op, word_t val, logic [IDX_W-1:0] idx);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      send_burst = $urandom_range(10, 50);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 6);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-OP_W-WORD_W-IDX_W){1'b0}}, idx, val, op};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  function automatic logic [OP_W-1:0] pick_op(int mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 70) return OP_PUSH;
        if (r < 80) return OP_DUP;
        if (r < 85) return OP_PEEK;
        if (r < 90) return OP_CONTAINS;
        if (r < 93) return OP_POP;
        if (r < 96) return OP_REVERSE;
        if (r < 98) return OP_UNUSED;
        return OP_CLEAR;
      end
      MIX_DRAIN: begin
        if (r < 55) return OP_POP;
        if (r < 65) return OP_PUSH;
        if (r < 75) return OP_PEEK;
        if (r < 85) return OP_CONTAINS;
        if (r < 92) return OP_REVERSE;
        if (r < 95) return OP_DUP;
        if (r < 97) return OP_UNUSED;
        return OP_CLEAR;
      end
      default: begin
        if (r < 30) return OP_PUSH;
        if (r < 55) return OP_POP;
        if (r < 63) return OP_DUP;
        if (r < 75) return OP_PEEK;
        if (r < 87) return OP_CONTAINS;
        if (r < 94) return OP_REVERSE;
        if (r < 97) return OP_CLEAR;
        return OP_UNUSED;
      end
    endcase
  endfunction

  // small values repeat often so contains finds matches
  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 15)) - 8;
    if (r == 4) return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 63));
    return IDX_W'($urandom_range(0, 15));
  endfunction

  // receiver
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (recv_burst > 0) begin
        recv_burst--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        recv_burst = $urandom_range(10, 50);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 6);
      end
      if (stall > 0 || hold_off) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // long receiver stall while the sender keeps offering words
  initial begin
    while (words_sent < HOLD_AFTER) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int total;
    int seg_len;
    int mix;
    logic [OP_W-1:0] op;
    while (rst) @(posedge clk);

    // empty-stack corner cases
    send_op(OP_CONTAINS, 5, '0);
    send_op(OP_POP, 0, '0);
    send_op(OP_DUP, 0, '0);
    send_op(OP_CLEAR, 0, '0);
    send_op(OP_REVERSE, 0, '0);
    send_op(OP_PEEK, 0, '0);
    send_op(OP_UNUSED, 32'sh7fff_ffff, 6'h3f);
    // extreme words, then queries around the edges of the held range
    send_op(OP_PUSH, 32'sh8000_0000, '0);
    send_op(OP_PUSH, 32'sh7fff_ffff, '0);
    send_op(OP_PUSH, 0, '0);
    send_op(OP_PUSH, -1, '0);
    send_op(OP_DUP, 0, '0);
    send_op(OP_PEEK, 0, '0);
    send_op(OP_PEEK, 0, 6'd4);
    send_op(OP_PEEK, 0, 6'd5);
    send_op(OP_PEEK, 0, 6'h3f);
    send_op(OP_CONTAINS, 32'sh7fff_ffff, '0);
    send_op(OP_CONTAINS, 12345, '0);
    send_op(OP_REVERSE, 0, '0);
    send_op(OP_PEEK, 0, '0);
    send_op(OP_POP, 0, '0);
    send_op(OP_UNUSED, -1, '0);
    send_op(OP_CLEAR, 0, '0);

    total = words_sent + RANDOM_WORDS;
    // first segment fills the stack so overflow shows up early
    mix     = MIX_FILL;
    seg_len = 90;
    while (words_sent < total) begin
      repeat (seg_len) begin
        op = pick_op(mix);
        send_op(op, pick_word(), pick_index());
      end
      mix     = $urandom_range(MIX_FILL, MIX_ANY);
      seg_len = $urandom_range(20, 80);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
